// ----- rtl/greedy_label_placer_top_macros.svh -----
// assertion macros for the greedy label placer checker
// no dependencies
`ifndef GREEDY_LABEL_PLACER_TOP_MACROS_SVH
`define GREEDY_LABEL_PLACER_TOP_MACROS_SVH
`define GLP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("glp check failed");
`define GLP_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("glp check failed");
`endif

// ----- rtl/glp_pkg.sv -----
// shared types and constants for the greedy label placer
// no dependencies
`default_nettype none
package glp_pkg;
  localparam int MaxLabels = 64;
  localparam int IdxW = $clog2(MaxLabels);
  localparam int CntW = $clog2(MaxLabels + 1);

  localparam logic [2:0] CfgCanvasW = 3'd0;
  localparam logic [2:0] CfgCanvasH = 3'd1;
  localparam logic [2:0] CfgMinFont = 3'd2;
  localparam logic [2:0] CfgMaxFont = 3'd3;
  localparam logic [2:0] CfgCharW   = 3'd4;
  localparam logic [2:0] CfgLineH   = 3'd5;
  localparam logic [2:0] CfgPad     = 3'd6;
  localparam logic [2:0] CfgMargin  = 3'd7;

  localparam logic [2:0] SideFallback = 3'd4;

  typedef struct packed {
    logic [11:0] canvas_w;
    logic [11:0] canvas_h;
    logic [7:0]  min_font;
    logic [7:0]  max_font;
    logic [11:0] char_w;
    logic [11:0] line_h;
    logic [5:0]  pad;
    logic [5:0]  margin;
  } cfg_t;

  // stored rectangle, signed coordinates
  typedef struct packed {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic [13:0] w;
    logic [13:0] h;
  } rect_t;

  typedef struct packed {
    logic        frame_start;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_w;
    logic [11:0] box_h;
    logic [8:0]  confidence;
    logic [5:0]  char_count;
  } item_t;
endpackage
`default_nettype wire

// ----- rtl/greedy_label_placer_top.sv -----
// channel   | dir | handshake               | payload
// s_axis    | in  | s_axis_tvalid/tready    | tdata item, tuser frame_start
// m_axis    | out | m_axis_tvalid/tready    | tdata result
// cfg       | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// front, per item: accept, one multiply step, 32 divide steps, hand-over; no new item until hand-over
// back, per item: accept, multiply, geometry, a scan over every stored rectangle, pick, output
// the queue lets the front work on the next item while the back scans
// a stalled result word holds the back, then the queue fills and the front stops
// reset clears control and the fill count; no clearing pass
// top level of the greedy label placer; depends on glp_pkg, glp_front, glp_queue, glp_back
`default_nettype none
module greedy_label_placer_top import glp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // box_x, box_y, box_w, box_h, confidence, char_count
  input  wire logic        s_axis_tuser,  // frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // label_x, label_y, font_px, side, store_full
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);
  cfg_t  cfg_q;
  item_t in_item, f_item, b_item;
  logic  f_valid, f_ready, b_valid, b_ready;
  logic [7:0] f_font, b_font;

  assign cfg_ready_o = 1'b1;
  assign in_item = '{frame_start: s_axis_tuser, box_x: s_axis_tdata[11:0],
                     box_y: s_axis_tdata[23:12], box_w: s_axis_tdata[35:24],
                     box_h: s_axis_tdata[47:36], confidence: s_axis_tdata[56:48],
                     char_count: s_axis_tdata[62:57]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{canvas_w: 12'd640, canvas_h: 12'd480, min_font: 8'd12, max_font: 8'd32,
                 char_w: 12'd154, line_h: 12'd307, pad: 6'd4, margin: 6'd2};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCanvasW: cfg_q.canvas_w <= cfg_data_i;
        CfgCanvasH: cfg_q.canvas_h <= cfg_data_i;
        CfgMinFont: cfg_q.min_font <= cfg_data_i[7:0];
        CfgMaxFont: cfg_q.max_font <= cfg_data_i[7:0];
        CfgCharW:   cfg_q.char_w   <= cfg_data_i;
        CfgLineH:   cfg_q.line_h   <= cfg_data_i;
        CfgPad:     cfg_q.pad      <= cfg_data_i[5:0];
        CfgMargin:  cfg_q.margin   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  glp_front u_front (.clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready), .in_item_i(in_item), .q_valid_o(f_valid),
    .q_ready_i(f_ready), .q_item_o(f_item), .q_font_o(f_font));

  glp_queue u_queue (.clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_item_i(f_item), .wr_font_i(f_font), .rd_valid_o(b_valid), .rd_ready_i(b_ready),
    .rd_item_o(b_item), .rd_font_o(b_font));

  glp_back u_back (.clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(b_valid), .q_ready_o(b_ready),
    .q_item_i(b_item), .q_font_i(b_font), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
endmodule
`default_nettype wire

// ----- rtl/glp_front.sv -----
// front: accepts items and works out the font size with a serial divider
// depends on glp_pkg
`default_nettype none
module glp_front import glp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire item_t       in_item_i,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output item_t            q_item_o,
  output logic [7:0]       q_font_o
);
  typedef enum logic [3:0] {
    FIdle = 4'b0001, FMul = 4'b0010, FDiv = 4'b0100, FOut = 4'b1000
  } fstate_e;

  fstate_e     state_q, state_d;
  item_t       item_q;
  logic [5:0]  cnt_q, cnt_d;
  logic signed [31:0] num_q, num_d;
  logic        neg_q, neg_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] dvs;
  logic [7:0]  font_q, font_d;
  logic [12:0] cy;
  logic [11:0] cyc;
  logic signed [31:0] mag;
  logic [32:0] trial;
  logic signed [33:0] fq;

  assign dvs = {12'd0, cfg_i.canvas_h, 8'd0};  // 2*h*128

  always_comb begin
    cy  = {1'b0, item_q.box_y} + {2'b0, item_q.box_h[11:1]};
    cyc = (cy > {1'b0, cfg_i.canvas_h}) ? cfg_i.canvas_h : cy[11:0];
    mag = 32'(signed'({1'b0, cfg_i.min_font})) * 32'(signed'({13'd0, cfg_i.canvas_h, 7'd0}))
        + 32'(signed'({1'b0, cyc})) * 32'(signed'({1'b0, cfg_i.max_font})
                                         - signed'({1'b0, cfg_i.min_font})) * 32'sd128
        + 32'(signed'({1'b0, item_q.confidence})) * 32'(signed'({1'b0, cfg_i.canvas_h}));
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    num_d = num_q;
    neg_d = neg_q;
    rem_d = rem_q;
    quo_d = quo_q;
    font_d = font_q;
    trial = '0;
    fq = '0;
    case (state_q)
      FIdle: if (in_valid_i) state_d = FMul;
      FMul: begin
        neg_d = mag[31];
        // |2n| + d, dividend for round half away
        num_d = (mag[31] ? -mag : mag) * 32'sd2 + signed'(dvs[31:0] >> 1);
        rem_d = '0;
        quo_d = '0;
        cnt_d = 6'd32;
        state_d = FDiv;
      end
      FDiv: begin
        trial = {rem_q, num_q[31]} - {1'b0, dvs};
        num_d = num_q <<< 1;
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], num_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = FOut;
      end
      FOut: begin
        fq = neg_q ? -34'(signed'({1'b0, quo_q})) : 34'(signed'({1'b0, quo_q}));
        if (cfg_i.canvas_h == 12'd0) fq = 34'(signed'({1'b0, cfg_i.min_font}));
        if (fq > 34'(signed'({1'b0, cfg_i.max_font}))) fq = 34'(signed'({1'b0, cfg_i.max_font}));
        if (fq < 34'(signed'({1'b0, cfg_i.min_font}))) fq = 34'(signed'({1'b0, cfg_i.min_font}));
        font_d = fq[7:0];
        if (q_ready_i) state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FIdle && in_valid_i) item_q <= in_item_i;
    cnt_q <= cnt_d;
    num_q <= num_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    font_q <= font_d;
  end

  assign in_ready_o = (state_q == FIdle);
  assign q_valid_o  = (state_q == FOut);
  assign q_item_o   = item_q;
  assign q_font_o   = font_d;
endmodule
`default_nettype wire

// ----- rtl/glp_queue.sv -----
// two-entry queue between the front and the back
// depends on glp_pkg
`default_nettype none
module glp_queue import glp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_valid_i,
  output logic       wr_ready_o,
  input  wire item_t wr_item_i,
  input  wire logic [7:0] wr_font_i,
  output logic       rd_valid_o,
  input  wire logic  rd_ready_i,
  output item_t      rd_item_o,
  output logic [7:0] rd_font_o
);
  item_t      item_q [2];
  logic [7:0] font_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = item_q[rp_q];
  assign rd_font_o  = font_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      item_q[wp_q] <= wr_item_i;
      font_q[wp_q] <= wr_font_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/glp_back.sv -----
// back: builds the four candidate rectangles, scans the store, picks and stores
// depends on glp_pkg
`default_nettype none
module glp_back import glp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  wire item_t       q_item_i,
  input  wire logic [7:0]  q_font_i,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata
);
  typedef enum logic [5:0] {
    BIdle = 6'b000001, BMul = 6'b000010, BGeom = 6'b000100,
    BScan = 6'b001000, BPick = 6'b010000, BOut = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;
  item_t   item_q;
  logic [7:0] font_q;
  logic [19:0] cf_q;
  logic [13:0] lw_q, lh_q;
  rect_t   cand_q [4];
  logic [3:0] ok_q, ok_d;
  logic [CntW-1:0] count_q, scan_q;
  rect_t   mem_q [MaxLabels];
  rect_t   rd_q;
  logic    rd_v_q;
  rect_t   frect;
  logic [2:0]  side_q, pick_side;
  logic signed [14:0] ax_q, ay_q, pick_x, pick_y;
  logic    full_q;
  logic    store;
  logic [25:0] lwp;
  logic [19:0] lhp;
  logic [18:0] lw_raw;
  logic [13:0] lw_sat;
  logic [12:0] half_h;
  logic signed [15:0] fy, cy;

  function automatic logic hit(rect_t a, rect_t b, logic [5:0] m);
    logic signed [17:0] ax2, bx2, ay2, by2;
    ax2 = 18'(a.x) + 18'(a.w) + 18'(m);
    bx2 = 18'(b.x) + 18'(b.w) + 18'(m);
    ay2 = 18'(a.y) + 18'(a.h) + 18'(m);
    by2 = 18'(b.y) + 18'(b.h) + 18'(m);
    return !(ax2 <= 18'(b.x) || bx2 <= 18'(a.x) || ay2 <= 18'(b.y) || by2 <= 18'(a.y));
  endfunction

  function automatic logic inside_canvas(rect_t r, cfg_t c);
    return !(r.x < 0 || r.y < 0 ||
             17'(r.x) + 17'(r.w) > 17'(signed'({1'b0, c.canvas_w})) ||
             17'(r.y) + 17'(r.h) > 17'(signed'({1'b0, c.canvas_h})));
  endfunction

  always_comb begin
    lwp = 26'(cf_q) * 26'(item_q.char_count);
    lhp = 20'(font_q) * 20'(cfg_i.line_h);
    // any width past the canvas behaves alike in every check, so clip it
    lw_raw = {1'b0, lwp[25:8]} + 19'({cfg_i.pad, 1'b0});
    lw_sat = (lw_raw > 19'd8191) ? 14'd8191 : lw_raw[13:0];
    half_h = 13'(item_q.box_h[11:1]);
    cy = 16'(signed'({1'b0, item_q.box_y})) + 16'(signed'({1'b0, half_h}))
       + 16'(signed'({1'b0, font_q[7:1]}));
    fy = 16'(signed'({1'b0, item_q.box_y})) - 16'(signed'({1'b0, font_q})) - 16'sd2;
    if (fy < 16'(signed'({1'b0, font_q}))) fy = 16'(signed'({1'b0, font_q}));
    frect.x = 15'(signed'({1'b0, item_q.box_x}));
    frect.y = 15'(fy) - 15'(signed'({1'b0, font_q}));
    frect.w = lw_q;
    frect.h = lh_q;
    pick_side = SideFallback;
    pick_x = frect.x;
    pick_y = frect.y + 15'(signed'({1'b0, font_q}));
    // lowest fitting side wins
    for (int s = 3; s >= 0; s--) begin
      if (ok_q[s]) begin
        pick_side = 3'(s);
        pick_x = cand_q[s].x;
        pick_y = cand_q[s].y + 15'(signed'({1'b0, font_q}));
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ok_d = ok_q;
    case (state_q)
      BIdle: if (q_valid_i) state_d = BMul;
      BMul:  state_d = BGeom;
      BGeom: state_d = BScan;
      BScan: begin
        for (int s = 0; s < 4; s++) begin
          // first scan cycle: bounds check
          if (scan_q == '0 && !rd_v_q) ok_d[s] = inside_canvas(cand_q[s], cfg_i);
          else if (rd_v_q && hit(cand_q[s], rd_q, cfg_i.margin)) ok_d[s] = 1'b0;
        end
        if (scan_q == count_q && !rd_v_q) state_d = BPick;
      end
      BPick: state_d = BOut;
      BOut:  if (m_axis_tready) state_d = BIdle;
      default: state_d = BIdle;
    endcase
  end

  assign store = (state_q == BOut) && m_axis_tready && !full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BIdle && q_valid_i && q_item_i.frame_start) count_q <= '0;
      else if (store) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q <= ok_d;
    case (state_q)
      BIdle: if (q_valid_i) begin
        item_q <= q_item_i;
        font_q <= q_font_i;
      end
      BMul: begin
        cf_q <= 20'(font_q) * 20'(cfg_i.char_w);
        lh_q <= 14'(lhp[19:8]) + 14'({cfg_i.pad, 1'b0});
      end
      BGeom: begin
        lw_q <= lw_sat;
        cand_q[0].x <= 15'(signed'({1'b0, item_q.box_x})) + 15'(signed'({1'b0, item_q.box_w}))
                     + 15'(signed'({1'b0, cfg_i.pad}));
        cand_q[0].y <= 15'(cy) - 15'(signed'({1'b0, font_q}));
        cand_q[1].x <= 15'(signed'({1'b0, item_q.box_x})) - 15'(signed'({1'b0, lw_sat}))
                     - 15'(signed'({1'b0, cfg_i.pad}));
        cand_q[1].y <= 15'(cy) - 15'(signed'({1'b0, font_q}));
        cand_q[2].x <= 15'(signed'({1'b0, item_q.box_x}));
        cand_q[2].y <= 15'(signed'({1'b0, item_q.box_y})) - 15'(signed'({1'b0, cfg_i.pad}))
                     - 15'(signed'({1'b0, font_q}));
        cand_q[3].x <= 15'(signed'({1'b0, item_q.box_x}));
        cand_q[3].y <= 15'(signed'({1'b0, item_q.box_y})) + 15'(signed'({1'b0, item_q.box_h}))
                     + 15'(signed'({1'b0, cfg_i.pad}));
        for (int s = 0; s < 4; s++) begin
          cand_q[s].w <= lw_sat;
          cand_q[s].h <= lh_q;
        end
        scan_q <= '0;
        rd_v_q <= 1'b0;
      end
      BScan: begin
        if (scan_q != count_q) begin
          rd_q <= mem_q[scan_q[IdxW-1:0]];
          rd_v_q <= 1'b1;
          scan_q <= scan_q + 1'b1;
        end else begin
          rd_v_q <= 1'b0;
        end
      end
      BPick: begin
        full_q <= (count_q == CntW'(MaxLabels));
        side_q <= pick_side;
        ax_q <= pick_x;
        ay_q <= pick_y;
      end
      default: ;
    endcase
  end

  // the chosen rectangle goes in when its result word leaves, unless the store is full
  always_ff @(posedge clk_i) begin
    if (store)
      mem_q[count_q[IdxW-1:0]] <= '{x: ax_q, y: ay_q - 15'(signed'({1'b0, font_q})),
                                   w: lw_q, h: lh_q};
  end

  logic [11:0] ox, oy;
  always_comb begin
    ox = (ax_q < 0) ? 12'd0 : (ax_q > 15'sd4095) ? 12'hFFF : ax_q[11:0];
    oy = (ay_q < 0) ? 12'd0 : (ay_q > 15'sd4095) ? 12'hFFF : ay_q[11:0];
  end

  assign q_ready_o = (state_q == BIdle);
  assign m_axis_tvalid = (state_q == BOut);
  assign m_axis_tdata = {4'd0, full_q, side_q, font_q, oy, ox};
endmodule
`default_nettype wire

// ----- rtl/glp_checker.sv -----
// port-level checks for the greedy label placer
// depends on greedy_label_placer_top_macros.svh
`default_nettype none
`include "greedy_label_placer_top_macros.svh"
module glp_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  `GLP_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `GLP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `GLP_ASSERT_IMP(a_side_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[34:32] <= 3'd4)
  `GLP_ASSERT_IMP(a_font_nz, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:24] != 8'd0)
endmodule
bind greedy_label_placer_top glp_props u_chk (.clk_i, .rst_ni, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata);
`default_nettype wire
